FILE: src/bxds_pkg.sv
// ----------------------------------------------------------------------------
// bxds_pkg
// Shared types and constants of the box average downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bxds_pkg;

  localparam int NumChan   = 4;   // bytes per pixel
  localparam int ChanW     = 8;   // bits per channel byte
  localparam int LaneW     = 16;  // bits per channel sum
  localparam int CfgW      = 12;  // width and height register width
  localparam int FactW     = 5;   // factor register width
  localparam int RowW      = 11;  // row counter width
  localparam int MaxHeight = 2048;
  localparam int CountW    = 9;   // pixels per block, up to 16 * 16
  localparam int QuotSteps = 8;   // one quotient bit per step
  localparam int StepW     = 3;
  localparam int AddrW     = 4;   // APB byte address width
  localparam int DataW     = 32;

  // Register indexes
  localparam logic [1:0] RegImageWidth   = 2'd0;
  localparam logic [1:0] RegImageHeight  = 2'd1;
  localparam logic [1:0] RegShrinkFactor = 2'd2;

  typedef logic [NumChan-1:0][LaneW-1:0] lanes_t;
  typedef logic [NumChan-1:0][ChanW-1:0] quot_t;

  typedef struct packed {
    logic [ChanW-1:0] chan_a;
    logic [ChanW-1:0] chan_b;
    logic [ChanW-1:0] chan_c;
    logic [ChanW-1:0] chan_d;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] mean_a;
    logic [ChanW-1:0] mean_b;
    logic [ChanW-1:0] mean_c;
    logic [ChanW-1:0] mean_d;
    logic             image_done;
  } pix_out_t;

  // Divider handshake with the control logic
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] count;
  } div_req_t;

endpackage

`default_nettype wire

FILE: src/bxds_divider.sv
// ----------------------------------------------------------------------------
// bxds_divider
// Four-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bxds_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bxds_pkg::div_req_t req_i,
  input  wire bxds_pkg::lanes_t  sums_i,
  output logic                   done_o,
  output bxds_pkg::quot_t        quot_o
);

  bxds_pkg::lanes_t                 rem_q, rem_d;
  bxds_pkg::quot_t                  quot_q, quot_d;
  logic [bxds_pkg::LaneW-1:0]       dvs_q, dvs_d;
  logic [bxds_pkg::StepW-1:0]       step_q, step_d;
  logic                             busy_q, busy_d;
  logic                             done_q, done_d;

  // The quotient never exceeds a byte, so start with the divisor shifted up
  // by seven and walk it down.
  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = sums_i;
      dvs_d  = bxds_pkg::LaneW'(req_i.count) << (bxds_pkg::QuotSteps - 1);
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int k = 0; k < bxds_pkg::NumChan; k++) begin
        if (rem_q[k] >= dvs_q) begin
          rem_d[k]  = rem_q[k] - dvs_q;
          quot_d[k] = {quot_q[k][bxds_pkg::ChanW-2:0], 1'b1};
        end else begin
          quot_d[k] = {quot_q[k][bxds_pkg::ChanW-2:0], 1'b0};
        end
      end
      dvs_d  = dvs_q >> 1;
      step_d = step_q + bxds_pkg::StepW'(1);
      if (step_q == bxds_pkg::StepW'(bxds_pkg::QuotSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: src/box_average_downscale.sv
// ----------------------------------------------------------------------------
// box_average_downscale
// A pixel that does not close a block row segment is only taken in; one that
// closes a segment adds to the line store (read, then add and write back); one
// that closes a block also waits for the divider and then for the output.
// Throughput is bound by the single-port line store and the 8-step divider.
// Reset clears control state, counters and configuration; the line store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_downscale #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_FACTOR = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pixel input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bxds_pkg::pix_in_t             in_pix_i,
  // block mean output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bxds_pkg::pix_out_t                 out_pix_o,
  // APB configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bxds_pkg::AddrW-1:0]    paddr,
  input  wire logic [bxds_pkg::DataW-1:0]    pwdata,
  output logic [bxds_pkg::DataW-1:0]         prdata,
  output logic                               pready
);

  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int FactCntW = $clog2(MAX_FACTOR);
  localparam int CmpW     = (ColW + 1 > bxds_pkg::CfgW) ? ColW + 1 : bxds_pkg::CfgW;
  localparam int CfgW     = bxds_pkg::CfgW;
  localparam int FactW    = bxds_pkg::FactW;
  localparam int CountW   = bxds_pkg::CountW;

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;  // take a pixel beat
  localparam logic [1:0] StAdd  = 2'd1;  // fold segment into column sum
  localparam logic [1:0] StDiv  = 2'd2;  // wait for the divider
  localparam logic [1:0] StPut  = 2'd3;  // hand mean to the output register

  function automatic bxds_pkg::lanes_t add_lanes(bxds_pkg::lanes_t x, bxds_pkg::lanes_t y);
    bxds_pkg::lanes_t r;
    for (int k = 0; k < bxds_pkg::NumChan; k++) begin
      r[k] = x[k] + y[k];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CfgW-1:0]  cfg_width_q, cfg_height_q;
  logic [FactW-1:0] cfg_factor_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic             cfg_hit;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[bxds_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  // Any write to a known register restarts the stream at the top of an image
  assign cfg_hit = cfg_wr && (cfg_idx == bxds_pkg::RegImageWidth ||
                              cfg_idx == bxds_pkg::RegImageHeight ||
                              cfg_idx == bxds_pkg::RegShrinkFactor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CfgW'(1);
      cfg_height_q <= CfgW'(1);
      cfg_factor_q <= FactW'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bxds_pkg::RegImageWidth:   cfg_width_q  <= pwdata[CfgW-1:0];
        bxds_pkg::RegImageHeight:  cfg_height_q <= pwdata[CfgW-1:0];
        bxds_pkg::RegShrinkFactor: cfg_factor_q <= pwdata[FactW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bxds_pkg::RegImageWidth:   prdata = bxds_pkg::DataW'(cfg_width_q);
      bxds_pkg::RegImageHeight:  prdata = bxds_pkg::DataW'(cfg_height_q);
      bxds_pkg::RegShrinkFactor: prdata = bxds_pkg::DataW'(cfg_factor_q);
      default:                   prdata = '0;
    endcase
  end

  // Clamp the registers into their usable range
  logic [FactW-1:0] eff_factor;
  logic [CmpW-1:0]  eff_width;
  logic [CfgW-1:0]  eff_height;

  always_comb begin
    eff_factor = cfg_factor_q;
    if (cfg_factor_q == '0) begin
      eff_factor = FactW'(1);
    end else if (cfg_factor_q > FactW'(MAX_FACTOR)) begin
      eff_factor = FactW'(MAX_FACTOR);
    end
    eff_width = CmpW'(cfg_width_q);
    if (cfg_width_q == '0) begin
      eff_width = CmpW'(1);
    end else if (CmpW'(cfg_width_q) > CmpW'(MAX_WIDTH)) begin
      eff_width = CmpW'(MAX_WIDTH);
    end
    eff_height = cfg_height_q;
    if (cfg_height_q == '0) begin
      eff_height = CfgW'(1);
    end else if (cfg_height_q > CfgW'(bxds_pkg::MaxHeight)) begin
      eff_height = CfgW'(bxds_pkg::MaxHeight);
    end
  end

  // --------------------------------------------------------------------------
  // Position tracking
  // --------------------------------------------------------------------------
  logic [1:0]                 state_q, state_d;
  logic [ColW-1:0]            col_q, bcol_q;
  logic [bxds_pkg::RowW-1:0]  row_q;
  logic [FactCntW-1:0]        cib_q, rib_q;
  bxds_pkg::lanes_t           row_partial_q, pix_lanes, row_partial_d;

  logic in_accept;
  logic col_last, row_last, seg_last, blk_row_last;
  logic [CountW-1:0] count_d;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;

  assign col_last     = (CmpW'(col_q) + CmpW'(1)) >= eff_width;
  assign row_last     = (CfgW'(row_q) + CfgW'(1)) >= eff_height;
  assign seg_last     = ((FactW'(cib_q) + FactW'(1)) >= eff_factor) || col_last;
  assign blk_row_last = ((FactW'(rib_q) + FactW'(1)) >= eff_factor) || row_last;
  assign count_d      = (CountW'(cib_q) + CountW'(1)) * (CountW'(rib_q) + CountW'(1));

  assign pix_lanes[0] = bxds_pkg::LaneW'(in_pix_i.chan_a);
  assign pix_lanes[1] = bxds_pkg::LaneW'(in_pix_i.chan_b);
  assign pix_lanes[2] = bxds_pkg::LaneW'(in_pix_i.chan_c);
  assign pix_lanes[3] = bxds_pkg::LaneW'(in_pix_i.chan_d);
  assign row_partial_d = (cib_q == '0) ? pix_lanes : add_lanes(row_partial_q, pix_lanes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      cib_q         <= '0;
      rib_q         <= '0;
      bcol_q        <= '0;
      row_partial_q <= '0;
    end else if (cfg_hit) begin
      col_q         <= '0;
      row_q         <= '0;
      cib_q         <= '0;
      rib_q         <= '0;
      bcol_q        <= '0;
      row_partial_q <= '0;
    end else if (in_accept) begin
      row_partial_q <= row_partial_d;
      if (col_last) begin
        // wrap to the start of the next line, or of the next image
        col_q  <= '0;
        cib_q  <= '0;
        bcol_q <= '0;
        if (row_last) begin
          row_q <= '0;
          rib_q <= '0;
        end else begin
          row_q <= row_q + bxds_pkg::RowW'(1);
          rib_q <= blk_row_last ? '0 : rib_q + FactCntW'(1);
        end
      end else begin
        col_q <= col_q + ColW'(1);
        if (seg_last) begin
          cib_q  <= '0;
          bcol_q <= bcol_q + ColW'(1);
        end else begin
          cib_q <= cib_q + FactCntW'(1);
        end
      end
    end
  end

  // Block context held for the store update and the output
  logic [ColW-1:0]   wr_addr_q;
  logic              first_row_q, last_row_q, img_done_q;
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (in_accept && seg_last) begin
      wr_addr_q   <= bcol_q;
      first_row_q <= (rib_q == '0);
      last_row_q  <= blk_row_last;
      img_done_q  <= col_last && row_last;
      count_q     <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line store of column sums: read on the segment end, written back in the next
  // cycle. No pixel is taken in between, so the two never collide.
  // --------------------------------------------------------------------------
  bxds_pkg::lanes_t col_mem [MAX_WIDTH];
  bxds_pkg::lanes_t rd_data_q;
  bxds_pkg::lanes_t sum_d;
  logic             mem_rd, mem_wr;

  assign mem_rd = in_accept && seg_last && (rib_q != '0);
  assign mem_wr = (state_q == StAdd);
  assign sum_d  = first_row_q ? row_partial_q : add_lanes(rd_data_q, row_partial_q);

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      col_mem[wr_addr_q] <= sum_d;
    end
    if (mem_rd) begin
      rd_data_q <= col_mem[bcol_q];
    end
  end

  // --------------------------------------------------------------------------
  // Divider and output register
  // --------------------------------------------------------------------------
  bxds_pkg::div_req_t div_req;
  logic               div_done;
  bxds_pkg::quot_t    div_quot;

  assign div_req.start = (state_q == StAdd) && last_row_q;
  assign div_req.count = count_q;

  bxds_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sums_i (sum_d),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  logic               out_valid_q;
  bxds_pkg::pix_out_t out_pix_q;
  logic               out_load;

  // Load once the register is empty or being drained this cycle
  assign out_load = (state_q == StPut) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_accept && seg_last) state_d = StAdd;
      StAdd:  state_d = last_row_q ? StDiv : StIdle;
      StDiv:  if (div_done) state_d = StPut;
      StPut:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q.mean_a     <= div_quot[0];
      out_pix_q.mean_b     <= div_quot[1];
      out_pix_q.mean_c     <= div_quot[2];
      out_pix_q.mean_d     <= div_quot[3];
      out_pix_q.image_done <= img_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> ##(bxds_pkg::QuotSteps + 1) div_done)
    else $error("divider result not ready after its fixed latency");

  a_seg_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && seg_last) |=> (state_q == StAdd && mem_wr))
    else $error("segment end did not fold into the line store");

  a_out_from_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StPut))
    else $error("output beat raised outside the output state");

endmodule

`default_nettype wire
